// ===== rtl/ltc_pkg.sv =====
`timescale 1ns / 1ps
package ltc_pkg;

  // opcodes
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // token kinds
  localparam logic [2:0] KIND_EMPTY  = 3'd0;
  localparam logic [2:0] KIND_SPACES = 3'd1;
  localparam logic [2:0] KIND_WORD   = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_SIGN   = 3'd4;
  localparam logic [2:0] KIND_LINE   = 3'd5;
  localparam logic [2:0] KIND_BLOCK  = 3'd6;

  // token status
  localparam logic [1:0] STAT_PROGRESS = 2'd0;
  localparam logic [1:0] STAT_DONE     = 2'd1;
  localparam logic [1:0] STAT_FAILED   = 2'd2;

  // first character of a sign, reduced to what pairing needs
  localparam logic [2:0] SF_OTHER = 3'd0;
  localparam logic [2:0] SF_EQ    = 3'd1;  // = ! > <
  localparam logic [2:0] SF_BAR   = 3'd2;
  localparam logic [2:0] SF_AMP   = 3'd3;
  localparam logic [2:0] SF_SLASH = 3'd4;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_BAR        = 8'h7C;
  localparam logic [7:0] CH_AMP        = 8'h26;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_9          = 8'h39;
  localparam logic [7:0] CH_LA         = 8'h61;
  localparam logic [7:0] CH_LZ         = 8'h7A;
  localparam logic [7:0] CH_UA         = 8'h41;
  localparam logic [7:0] CH_UZ         = 8'h5A;

  typedef struct packed {
    logic       is_space;
    logic       is_word;
    logic       is_quote;
    logic       is_slash;
    logic       is_star;
    logic       is_equal;
    logic       is_bar;
    logic       is_amp;
    logic       is_newline;
    logic [2:0] sign_code;
  } ltc_class_t;

  typedef struct packed {
    logic [1:0] op;
    ltc_class_t cls;
  } ltc_item_t;

  // first member in the highest bits, so accepted lands in bit 0
  typedef struct packed {
    logic [1:0] token_status;
    logic [2:0] token_kind;
    logic       drop_last;
    logic       clear_text;
    logic       append_char;
    logic       accepted;
  } ltc_result_t;

  localparam int unsigned ResultW = $bits(ltc_result_t);

endpackage

// ===== rtl/ltc_front.sv =====
`timescale 1ns / 1ps
module ltc_front (
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        char_i,
  output ltc_pkg::ltc_item_t item_o
);
  import ltc_pkg::*;

  logic is_eq_lead;

  always_comb begin
    item_o.op             = opcode_i;
    item_o.cls.is_space   = (char_i == CH_SPACE) || (char_i == CH_TAB) ||
                            (char_i == CH_CR) || (char_i == CH_LF);
    item_o.cls.is_word    = ((char_i >= CH_0) && (char_i <= CH_9)) ||
                            ((char_i >= CH_LA) && (char_i <= CH_LZ)) ||
                            ((char_i >= CH_UA) && (char_i <= CH_UZ)) ||
                            (char_i == CH_UNDERSCORE);
    item_o.cls.is_quote   = (char_i == CH_QUOTE);
    item_o.cls.is_slash   = (char_i == CH_SLASH);
    item_o.cls.is_star    = (char_i == CH_STAR);
    item_o.cls.is_equal   = (char_i == CH_EQUAL);
    item_o.cls.is_bar     = (char_i == CH_BAR);
    item_o.cls.is_amp     = (char_i == CH_AMP);
    item_o.cls.is_newline = (char_i == CH_LF);
    is_eq_lead = (char_i == CH_EQUAL) || (char_i == CH_BANG) ||
                 (char_i == CH_GREATER) || (char_i == CH_LESS);
    priority if (is_eq_lead) begin
      item_o.cls.sign_code = SF_EQ;
    end else if (char_i == CH_BAR) begin
      item_o.cls.sign_code = SF_BAR;
    end else if (char_i == CH_AMP) begin
      item_o.cls.sign_code = SF_AMP;
    end else if (char_i == CH_SLASH) begin
      item_o.cls.sign_code = SF_SLASH;
    end else begin
      item_o.cls.sign_code = SF_OTHER;
    end
  end

endmodule

// ===== rtl/ltc_fifo.sv =====
`timescale 1ns / 1ps
module ltc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ltc_pkg::ltc_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ltc_pkg::ltc_item_t pop_item_o
);
  import ltc_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  ltc_item_t         mem_q [DEPTH];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== rtl/ltc_back.sv =====
`timescale 1ns / 1ps
module ltc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  ltc_pkg::ltc_item_t   item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ltc_pkg::ltc_result_t result_o
);
  import ltc_pkg::*;

  logic [2:0]  kind_q, kind_d;
  logic [1:0]  status_q, status_d;
  logic [2:0]  sign_q, sign_d;
  logic        star_q, star_d;
  logic        out_valid_q;
  ltc_result_t res_q, res_d;
  logic        acc, app, clr, drop;
  ltc_class_t  cls;

  assign cls         = item_i.cls;
  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    kind_d   = kind_q;
    status_d = status_q;
    sign_d   = sign_q;
    star_d   = star_q;
    acc      = 1'b0;
    app      = 1'b0;
    clr      = 1'b0;
    drop     = 1'b0;
    if (item_i.op == OP_RESTART) begin
      kind_d   = KIND_EMPTY;
      status_d = STAT_PROGRESS;
      sign_d   = SF_OTHER;
      star_d   = 1'b0;
      clr      = 1'b1;
    end else if ((item_i.op == OP_FINISH) && (status_q == STAT_PROGRESS)) begin
      if ((kind_q == KIND_EMPTY) || (kind_q == KIND_STRING) || (kind_q == KIND_BLOCK)) begin
        status_d = STAT_FAILED;
      end else if (kind_q <= KIND_BLOCK) begin
        status_d = STAT_DONE;
      end
    end else if ((item_i.op == OP_ADD) && (status_q == STAT_PROGRESS)) begin
      unique case (kind_q)
        KIND_EMPTY: begin
          acc = 1'b1;
          clr = 1'b1;
          priority if (cls.is_space) begin
            kind_d = KIND_SPACES;
            app    = 1'b1;
          end else if (cls.is_word) begin
            kind_d = KIND_WORD;
            app    = 1'b1;
          end else if (cls.is_quote) begin
            kind_d = KIND_STRING;
          end else begin
            kind_d = KIND_SIGN;
            sign_d = cls.sign_code;
            app    = 1'b1;
          end
        end
        KIND_SPACES: begin
          if (cls.is_space) begin
            acc = 1'b1;
            app = 1'b1;
          end else begin
            status_d = STAT_DONE;
          end
        end
        KIND_WORD: begin
          if (cls.is_word) begin
            acc = 1'b1;
            app = 1'b1;
          end else begin
            status_d = STAT_DONE;
          end
        end
        KIND_STRING: begin
          acc = 1'b1;
          if (cls.is_quote) begin
            status_d = STAT_DONE;
          end else begin
            app = 1'b1;
          end
        end
        KIND_SIGN: begin
          priority if ((sign_q == SF_SLASH) && cls.is_slash) begin
            acc    = 1'b1;
            clr    = 1'b1;
            kind_d = KIND_LINE;
          end else if ((sign_q == SF_SLASH) && cls.is_star) begin
            acc    = 1'b1;
            clr    = 1'b1;
            kind_d = KIND_BLOCK;
            star_d = 1'b0;
          end else if (((sign_q == SF_EQ) && cls.is_equal) ||
                       ((sign_q == SF_BAR) && cls.is_bar) ||
                       ((sign_q == SF_AMP) && cls.is_amp)) begin
            acc      = 1'b1;
            app      = 1'b1;
            status_d = STAT_DONE;
          end else begin
            status_d = STAT_DONE;
          end
        end
        KIND_LINE: begin
          if (cls.is_newline) begin
            status_d = STAT_DONE;
          end else begin
            acc = 1'b1;
            app = 1'b1;
          end
        end
        KIND_BLOCK: begin
          acc = 1'b1;
          if (cls.is_slash && star_q) begin
            drop     = 1'b1;
            star_d   = 1'b0;
            status_d = STAT_DONE;
          end else begin
            app    = 1'b1;
            star_d = cls.is_star;
          end
        end
        default: begin
        end
      endcase
    end
    res_d.accepted     = acc;
    res_d.append_char  = app;
    res_d.clear_text   = clr;
    res_d.drop_last    = drop;
    res_d.token_kind   = kind_d;
    res_d.token_status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_EMPTY;
      status_q    <= STAT_PROGRESS;
      sign_q      <= SF_OTHER;
      star_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        kind_q   <= kind_d;
        status_q <= status_d;
        sign_q   <= sign_d;
        star_q   <= star_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/lexer_token_classifier_unit.sv =====
`timescale 1ns / 1ps
// A word accepted on the slave side is written into the input queue at the accepting edge, then its
// state update is registered into the output register, from which it is offered on the master side.
// Throughput: one word per cycle while the master side does not stall.
// The input queue absorbs up to FIFO_DEPTH words while the master side stalls.
// Reset (rst_ni low, asynchronous): empty token in progress, queue and output cleared.
module lexer_token_classifier_unit #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_in
  input  logic [1:0]  s_tuser_i,   // [1:0] opcode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o    // [0] accepted, [1] append_char, [2] clear_text,
                                   // [3] drop_last, [6:4] token_kind, [8:7] token_status
);
  import ltc_pkg::*;

  ltc_item_t   in_item;
  ltc_item_t   q_item;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  ltc_result_t result;

  ltc_front u_front (
    .opcode_i (s_tuser_i),
    .char_i   (s_tdata_i),
    .item_o   (in_item)
  );

  ltc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_tvalid_i),
    .push_item_i (in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  ltc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .result_o    (result)
  );

  assign s_tready_o = !q_full;
  assign m_tdata_o  = {(16 - ResultW)'(0), result};

  // closing a block comment always takes the slash and completes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && result.drop_last |->
      result.accepted && (result.token_kind == KIND_BLOCK) &&
      (result.token_status == STAT_DONE))
    else $error("drop_last outside a closing block comment");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && result.append_char |-> result.accepted)
    else $error("append without accept");

  // a clear without accept only comes from a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && result.clear_text && !result.accepted |->
      (result.token_kind == KIND_EMPTY) && (result.token_status == STAT_PROGRESS))
    else $error("clear without accept outside restart");

  // a pop only happens from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
